@@ rtl/core/shared_memory_race_detector_assert.svh @@
// ----------------------------------------------------------------------------
// Shared memory race detector assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHARED_MEMORY_RACE_DETECTOR_ASSERT_SVH
`define SHARED_MEMORY_RACE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define SRD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srd assertion failed");

// next-cycle implication
`define SRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srd assertion failed");

`endif

@@ rtl/core/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// Shared memory race detector package
// Widths, op and race codes, shadow entry and controller interface types.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int SHARED_BYTES = 16384;
  localparam int MAX_THREADS  = 1024;
  localparam int ADDR_W       = $clog2(SHARED_BYTES);
  localparam int THREAD_W     = 10;
  localparam int MARK_W       = 11;
  localparam int DATA_W       = 8;
  localparam int EPOCH_W      = 8;

  localparam logic [MARK_W-1:0]  MARK_NONE  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
  localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(SHARED_BYTES - 1);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STORE   = 2'd1;
  localparam logic [1:0] OP_BARRIER = 2'd2;

  localparam logic [1:0] KIND_NONE              = 2'd0;
  localparam logic [1:0] KIND_LOAD_AFTER_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STORE_AFTER_WRITE = 2'd2;
  localparam logic [1:0] KIND_STORE_AFTER_READ  = 2'd3;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [MARK_W-1:0]  writer;
    logic [MARK_W-1:0]  reader;
  } srd_entry_t;

  typedef struct packed {
    logic               accept;
    logic               eval;
    logic               clr_en;
    logic [ADDR_W-1:0]  clr_addr;
    logic [EPOCH_W-1:0] epoch;
  } srd_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic barrier;
  } srd_sts_t;

endpackage

@@ rtl/core/srd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Shared memory race detector controller
// Sequences clearing pass, accept and evaluate; owns the barrier epoch.
// ----------------------------------------------------------------------------
module srd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  srd_pkg::srd_sts_t sts,
  output srd_pkg::srd_cmd_t cmd
);
  import srd_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               accept;

  assign in_tready = (state_r == ST_IDLE) && sts.slot_free;
  assign accept    = in_tready && in_tvalid;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    epoch_nxt   = epoch_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
          epoch_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        if (sts.barrier) begin
          if (epoch_r == EPOCH_LAST) begin
            state_nxt   = ST_CLEAR;
            clr_cnt_nxt = '0;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      epoch_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      epoch_r   <= epoch_nxt;
    end
  end

  assign cmd.accept   = accept;
  assign cmd.eval     = (state_r == ST_EVAL);
  assign cmd.clr_en   = (state_r == ST_CLEAR);
  assign cmd.clr_addr = clr_cnt_r;
  assign cmd.epoch    = epoch_r;

endmodule

@@ rtl/core/srd_datapath.sv @@
// ----------------------------------------------------------------------------
// Shared memory race detector datapath
// Shadow memory, beat registers, race check and result register.
// ----------------------------------------------------------------------------
module srd_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srd_pkg::srd_cmd_t               cmd,
  output srd_pkg::srd_sts_t               sts,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  input  logic [1:0]                      in_op,
  input  logic [srd_pkg::THREAD_W-1:0]    in_thread,
  input  logic [srd_pkg::ADDR_W-1:0]      in_address,
  input  logic [srd_pkg::DATA_W-1:0]      in_old_data,
  input  logic [srd_pkg::DATA_W-1:0]      in_new_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_race,
  output logic [1:0]                      out_race_kind,
  output logic [srd_pkg::THREAD_W-1:0]    out_other_thread
);
  import srd_pkg::*;

  srd_entry_t mem [SHARED_BYTES];

  logic                always_check_writes_r;
  logic [1:0]          op_r;
  logic [THREAD_W-1:0] thread_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   old_r, new_r;
  srd_entry_t          rd_q_r;

  logic                out_valid_r;
  logic [1:0]          kind_r;
  logic [THREAD_W-1:0] other_r;

  logic [MARK_W-1:0]   w_eff, r_eff, me;
  logic                in_range, fw, fr, changed;
  logic [1:0]          kind;
  logic [MARK_W-1:0]   other;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  srd_entry_t          wr_data;

  assign me       = {1'b0, thread_r};
  assign w_eff    = (rd_q_r.tag == cmd.epoch) ? rd_q_r.writer : MARK_NONE;
  assign r_eff    = (rd_q_r.tag == cmd.epoch) ? rd_q_r.reader : MARK_NONE;
  assign fw       = (w_eff != MARK_NONE) && (w_eff != me);
  assign fr       = (r_eff != MARK_NONE) && (r_eff != me);
  assign changed  = always_check_writes_r || (old_r != new_r);
  assign in_range = ({1'b0, addr_r} < (ADDR_W + 1)'(SHARED_BYTES)) &&
                    ({1'b0, thread_r} < (THREAD_W + 1)'(MAX_THREADS));

  always_comb begin
    kind    = KIND_NONE;
    other   = '0;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '{tag: cmd.epoch, writer: w_eff, reader: r_eff};
    if (cmd.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = cmd.clr_addr;
      wr_data = '{tag: '0, writer: MARK_NONE, reader: MARK_NONE};
    end else if (cmd.eval && in_range) begin
      priority if (op_r == OP_LOAD) begin
        if (fw) begin
          kind  = KIND_LOAD_AFTER_WRITE;
          other = w_eff;
        end else begin
          wr_en          = 1'b1;
          wr_data.reader = me;
        end
      end else if (op_r == OP_STORE) begin
        if (changed && fw) begin
          kind  = KIND_STORE_AFTER_WRITE;
          other = w_eff;
        end else if (changed && fr) begin
          kind  = KIND_STORE_AFTER_READ;
          other = r_eff;
        end else begin
          wr_en          = 1'b1;
          wr_data.writer = me;
        end
      end else begin
        wr_en = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.accept) rd_q_r <= mem[in_address];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      thread_r <= in_thread;
      addr_r   <= in_address;
      old_r    <= in_old_data;
      new_r    <= in_new_data;
    end
    if (cmd.eval) begin
      kind_r  <= kind;
      other_r <= other[THREAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      always_check_writes_r <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (cfg_wr_en) always_check_writes_r <= cfg_wr_data;
      if (cmd.eval) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.slot_free    = !out_valid_r || out_ready;
  assign sts.barrier      = (op_r == OP_BARRIER);
  assign out_valid        = out_valid_r;
  assign out_race         = (kind_r != KIND_NONE);
  assign out_race_kind    = kind_r;
  assign out_other_thread = other_r;

endmodule

@@ rtl/core/shared_memory_race_detector.sv @@
// ----------------------------------------------------------------------------
// Shared memory race detector
// Input beats are byte accesses (tuser = op; tdata = thread, address, old and
// new byte). Each beat yields one result beat: race flag, race kind and the
// conflicting thread. A 16384 x 30 bit shadow memory holds last writer, last
// reader and an epoch tag per byte; barriers bump the epoch.
// Accept registers the beat and its shadow entry; the evaluate state checks,
// writes back and loads the result register before the next input is taken.
// Reset starts a clearing pass over all 16384 shadow entries with in_tready
// low; the same pass runs after every 256th barrier when the epoch counter wraps.
// A result waits in the output register while out_tready is low; a new input
// is taken once that register is empty or being drained. The user must write
// always_check_writes via cfg_wr_en/cfg_wr_data only while idle; not enforced.
// ----------------------------------------------------------------------------
`include "shared_memory_race_detector_assert.svh"

module shared_memory_race_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // always_check_writes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // thread[9:0], address[23:10], old_data, new_data
  input  logic [1:0]  in_tuser,      // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // other_thread[9:0], zero fill
  output logic [2:0]  out_tuser      // race[0], race_kind[2:1]
);
  import srd_pkg::*;

  srd_cmd_t            cmd;
  srd_sts_t            sts;
  logic                race;
  logic [1:0]          race_kind;
  logic [THREAD_W-1:0] other_thread;

  srd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_op            (in_tuser),
    .in_thread        (in_tdata[9:0]),
    .in_address       (in_tdata[23:10]),
    .in_old_data      (in_tdata[31:24]),
    .in_new_data      (in_tdata[39:32]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_race         (race),
    .out_race_kind    (race_kind),
    .out_other_thread (other_thread)
  );

  assign out_tdata = {6'd0, other_thread};
  assign out_tuser = {race_kind, race};

  `SRD_ASSERT_IMPL(a_no_race_clean, out_tvalid && !race, race_kind == KIND_NONE && other_thread == '0)
  `SRD_ASSERT_IMPL(a_result_follows, in_tvalid && in_tready, ##2 out_tvalid)
  `SRD_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  `SRD_ASSERT_IMPL(a_no_accept_in_clear, cmd.clr_en, !in_tready)

endmodule
